@@ rtl/arpc_pkg.sv @@
// Shared constants, codes and types of the ARP cache table.
`timescale 1ns / 1ps
package arpc_pkg;

  // default geometry
  localparam int DEF_CACHE_ENTRIES = 16;
  localparam int DEF_PA_BITS       = 32;

  // fixed field widths
  localparam int PA_IN_W   = 32;
  localparam int MAC_W     = 48;
  localparam int AGE_W     = 8;
  localparam int ACT_W     = 3;
  localparam int ST_W      = 3;
  localparam int IDX_OUT_W = 4;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_W     = 8;

  // actions
  localparam logic [ACT_W-1:0] ACT_REFRESH = 3'd0;
  localparam logic [ACT_W-1:0] ACT_RESERVE = 3'd1;
  localparam logic [ACT_W-1:0] ACT_LOOKUP  = 3'd2;
  localparam logic [ACT_W-1:0] ACT_ADD     = 3'd3;
  localparam logic [ACT_W-1:0] ACT_REMOVE  = 3'd4;
  localparam logic [ACT_W-1:0] ACT_CLEAR   = 3'd5;

  // result status
  localparam logic [ST_W-1:0] ST_MISS    = 3'd0;
  localparam logic [ST_W-1:0] ST_HIT     = 3'd1;
  localparam logic [ST_W-1:0] ST_PENDING = 3'd2;
  localparam logic [ST_W-1:0] ST_DONE    = 3'd3;
  localparam logic [ST_W-1:0] ST_FAIL    = 3'd4;

  // configuration register indexes and reset values
  localparam logic [CFG_IDX_W-1:0] CFG_FULL_AGE    = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PENDING_AGE = 1'd1;
  localparam logic [CFG_W-1:0]     FULL_AGE_RST    = 8'd150;
  localparam logic [CFG_W-1:0]     PENDING_AGE_RST = 8'd5;

  localparam logic [AGE_W-1:0] AGE_MAX = 8'hFF;

  // compare unit flags for one row
  typedef struct packed {
    logic pa_eq;
    logic mac_eq;
    logic age_lt;
  } cmp_res_t;

endpackage

@@ rtl/arpc_in_if.sv @@
// Request channel: action and operands.
`timescale 1ns / 1ps
interface arpc_in_if import arpc_pkg::*;;
  logic               valid;
  logic               ready;
  logic [ACT_W-1:0]   action;
  logic [PA_IN_W-1:0] protocol_address;
  logic [MAC_W-1:0]   hw_address;
  logic [AGE_W-1:0]   add_age;

  modport source (output valid, action, protocol_address, hw_address, add_age,
                  input ready);
  modport sink (input valid, action, protocol_address, hw_address, add_age,
                output ready);
endinterface

@@ rtl/arpc_out_if.sv @@
// Result channel: status, MAC and row index.
`timescale 1ns / 1ps
interface arpc_out_if import arpc_pkg::*;;
  logic                 valid;
  logic                 ready;
  logic [ST_W-1:0]      status;
  logic [MAC_W-1:0]     mac_out;
  logic [IDX_OUT_W-1:0] entry_index;

  modport source (output valid, status, mac_out, entry_index, input ready);
  modport sink (input valid, status, mac_out, entry_index, output ready);
endinterface

@@ rtl/arpc_cmp.sv @@
// Shared row compare unit: address match, MAC match, age below running minimum.
`timescale 1ns / 1ps
module arpc_cmp import arpc_pkg::*; #(
  parameter int PAW = 32
) (
  input  logic [PAW-1:0]   row_pa,
  input  logic [MAC_W-1:0] row_mac,
  input  logic [AGE_W-1:0] row_age,
  input  logic [PAW-1:0]   op_pa,
  input  logic [MAC_W-1:0] op_mac,
  input  logic [AGE_W-1:0] min_age,
  output cmp_res_t         res
);

  always_comb begin
    res.pa_eq  = (row_pa == op_pa);
    res.mac_eq = (row_mac == op_mac);
    res.age_lt = (row_age < min_age);
  end

endmodule

@@ rtl/arpc_row_store.sv @@
// Row memory with per-row live bits; a row that is not live reads as all zero.
`timescale 1ns / 1ps
module arpc_row_store import arpc_pkg::*; #(
  parameter int ENTRIES = 16,
  parameter int PAW     = 32,
  parameter int IW      = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             rd_en,
  input  logic [IW-1:0]    rd_addr,
  output logic [PAW-1:0]   rd_pa,
  output logic [MAC_W-1:0] rd_mac,
  output logic [AGE_W-1:0] rd_age,
  output logic             rd_valid,
  input  logic             wr_en,
  input  logic [IW-1:0]    wr_addr,
  input  logic [PAW-1:0]   wr_pa,
  input  logic [MAC_W-1:0] wr_mac,
  input  logic [AGE_W-1:0] wr_age,
  input  logic             wr_valid,
  input  logic             clr_en,
  input  logic [IW-1:0]    clr_addr,
  input  logic             clr_all
);

  localparam int WW = 1 + AGE_W + MAC_W + PAW;

  logic [WW-1:0]      mem [ENTRIES];
  logic [WW-1:0]      mem_q_r;
  logic [ENTRIES-1:0] live_r, live_nxt;
  logic               live_q_r;
  logic [WW-1:0]      word;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= {wr_valid, wr_age, wr_mac, wr_pa};
    end
    if (rd_en) begin
      mem_q_r <= mem[rd_addr];
    end
  end

  // write marks a row live, a row clear drops it, clear-all drops every row
  always_comb begin
    live_nxt = live_r;
    if (clr_all) begin
      live_nxt = '0;
    end else begin
      if (wr_en) live_nxt[wr_addr] = 1'b1;
      if (clr_en) live_nxt[clr_addr] = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      live_r   <= '0;
      live_q_r <= 1'b0;
    end else begin
      live_r <= live_nxt;
      if (rd_en) live_q_r <= live_r[rd_addr];
    end
  end

  assign word = live_q_r ? mem_q_r : '0;
  assign {rd_valid, rd_age, rd_mac, rd_pa} = word;

endmodule

@@ rtl/arp_cache_table_core.sv @@
// ARP cache table top level: sequencer, config registers and result register.
// A full scan reads every row; a row hit ends the scan early; clear and undefined
//   actions skip the scan. One request is in flight at a time: a new one is taken
//   only once the last result has moved into the output register. Scan speed is
//   set by the one-row-per-cycle read port of the row memory and one compare unit.
// Reset (rst_n, synchronous): all rows invalid and zero, full_age 150,
//   pending_age 5, no result pending. No clearing pass is needed.
`timescale 1ns / 1ps
module arp_cache_table_core import arpc_pkg::*; #(
  parameter int CACHE_ENTRIES = DEF_CACHE_ENTRIES,
  parameter int PA_BITS       = DEF_PA_BITS
) (
  input  logic                 clk,
  input  logic                 rst_n,
  arpc_in_if.sink              in_ch,
  arpc_out_if.source           out_ch,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  // stored address width: operand is 32 bits, masked to PA_BITS
  localparam int PAW = (PA_BITS < PA_IN_W) ? PA_BITS : PA_IN_W;
  localparam int IW  = $clog2(CACHE_ENTRIES);
  localparam int CW  = IW + 1;
  localparam logic [CW-1:0] N_C      = CW'(CACHE_ENTRIES);
  localparam logic [IW-1:0] LAST_ROW = IW'(CACHE_ENTRIES - 1);

  // sequencer states
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_FIN  = 2'd2;
  localparam logic [1:0] S_EMIT = 2'd3;

  logic [1:0]       state_r, state_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;       // next row to read
  logic             dv_r, dv_nxt;         // read data in flight is valid
  logic [IW-1:0]    di_r, di_nxt;         // row index of read data
  logic [ACT_W-1:0] op_act_r;
  logic [PAW-1:0]   op_pa_r;
  logic [MAC_W-1:0] op_mac_r;
  logic [AGE_W-1:0] op_age_r;

  // refresh/reserve scan trackers
  logic             pa_fnd_r, pa_fnd_nxt;
  logic [IW-1:0]    pa_row_r, pa_row_nxt;
  logic             mac_fnd_r, mac_fnd_nxt;
  logic [IW-1:0]    mac_row_r, mac_row_nxt;
  logic [AGE_W-1:0] min_r, min_nxt;
  logic [IW-1:0]    use_r, use_nxt;
  logic [MAC_W-1:0] use_mac_r, use_mac_nxt;

  // finished result waiting for the output register
  logic [ST_W-1:0]  res_st_r, res_st_nxt;
  logic [MAC_W-1:0] res_mac_r, res_mac_nxt;
  logic [IW-1:0]    res_idx_r, res_idx_nxt;

  logic             out_valid_r;
  logic [ST_W-1:0]  out_st_r;
  logic [MAC_W-1:0] out_mac_r;
  logic [IDX_OUT_W-1:0] out_idx_r;

  logic [CFG_W-1:0] full_age_r, pend_age_r;

  // row store ports
  logic             rd_en;
  logic [PAW-1:0]   row_pa;
  logic [MAC_W-1:0] row_mac;
  logic [AGE_W-1:0] row_age;
  logic             row_valid;
  logic             wr_en;
  logic [IW-1:0]    wr_addr;
  logic [PAW-1:0]   wr_pa;
  logic [MAC_W-1:0] wr_mac;
  logic [AGE_W-1:0] wr_age;
  logic             wr_valid;
  logic             clr_en;
  logic [IW-1:0]    clr_addr;
  logic             clr_all;

  cmp_res_t         cmp;
  logic             in_xfer;
  logic             emit_go;
  logic             have_mac;
  logic             mac_eq_g;
  logic             done;
  logic [IW+IDX_OUT_W-1:0] idx_ext;

  assign in_xfer  = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (state_r == S_IDLE);
  assign emit_go  = (state_r == S_EMIT) && (!out_valid_r || out_ch.ready);
  assign have_mac = (op_act_r == ACT_REFRESH);
  assign mac_eq_g = have_mac && cmp.mac_eq;
  assign clr_all  = in_xfer && (in_ch.action == ACT_CLEAR);

  arpc_row_store #(
    .ENTRIES (CACHE_ENTRIES),
    .PAW     (PAW),
    .IW      (IW)
  ) u_store (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd_en    (rd_en),
    .rd_addr  (cnt_r[IW-1:0]),
    .rd_pa    (row_pa),
    .rd_mac   (row_mac),
    .rd_age   (row_age),
    .rd_valid (row_valid),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_pa    (wr_pa),
    .wr_mac   (wr_mac),
    .wr_age   (wr_age),
    .wr_valid (wr_valid),
    .clr_en   (clr_en),
    .clr_addr (clr_addr),
    .clr_all  (clr_all)
  );

  arpc_cmp #(
    .PAW (PAW)
  ) u_cmp (
    .row_pa  (row_pa),
    .row_mac (row_mac),
    .row_age (row_age),
    .op_pa   (op_pa_r),
    .op_mac  (op_mac_r),
    .min_age (min_r),
    .res     (cmp)
  );

  // Sequencer. A scan reads one row per cycle; compare happens in the next cycle
  // on the registered read data. Hits end the scan early; otherwise the
  // final decision is made in S_FIN from the trackers.
  always_comb begin
    state_nxt   = state_r;
    cnt_nxt     = cnt_r;
    dv_nxt      = 1'b0;
    di_nxt      = di_r;
    pa_fnd_nxt  = pa_fnd_r;
    pa_row_nxt  = pa_row_r;
    mac_fnd_nxt = mac_fnd_r;
    mac_row_nxt = mac_row_r;
    min_nxt     = min_r;
    use_nxt     = use_r;
    use_mac_nxt = use_mac_r;
    res_st_nxt  = res_st_r;
    res_mac_nxt = res_mac_r;
    res_idx_nxt = res_idx_r;
    rd_en       = 1'b0;
    wr_en       = 1'b0;
    wr_addr     = di_r;
    wr_pa       = op_pa_r;
    wr_mac      = op_mac_r;
    wr_age      = full_age_r;
    wr_valid    = 1'b1;
    clr_en      = 1'b0;
    clr_addr    = di_r;
    done        = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          cnt_nxt     = '0;
          pa_fnd_nxt  = 1'b0;
          mac_fnd_nxt = 1'b0;
          min_nxt     = AGE_MAX;
          use_nxt     = '0;
          res_mac_nxt = '0;
          res_idx_nxt = '0;
          if (in_ch.action == ACT_CLEAR) begin
            res_st_nxt = ST_DONE;
            state_nxt  = S_EMIT;
          end else if (in_ch.action > ACT_CLEAR) begin
            res_st_nxt = ST_FAIL;
            state_nxt  = S_EMIT;
          end else begin
            state_nxt = S_SCAN;
          end
        end
      end

      S_SCAN: begin
        if (cnt_r < N_C) begin
          rd_en   = 1'b1;
          cnt_nxt = cnt_r + 1'b1;
          dv_nxt  = 1'b1;
          di_nxt  = cnt_r[IW-1:0];
        end
        if (dv_r) begin
          unique case (op_act_r)
            ACT_REFRESH, ACT_RESERVE: begin
              if (di_r == '0) use_mac_nxt = row_mac;
              if (cmp.pa_eq) begin
                if (!have_mac) begin
                  // reserve on a known address leaves the row as it is
                  done        = 1'b1;
                  res_st_nxt  = ST_DONE;
                  res_idx_nxt = di_r;
                end else if (cmp.mac_eq) begin
                  // full match: renew
                  wr_en       = 1'b1;
                  done        = 1'b1;
                  res_st_nxt  = ST_DONE;
                  res_idx_nxt = di_r;
                end else begin
                  pa_fnd_nxt = 1'b1;
                  pa_row_nxt = di_r;
                end
              end else if (mac_eq_g) begin
                mac_fnd_nxt = 1'b1;
                mac_row_nxt = di_r;
              end else if (cmp.age_lt) begin
                min_nxt     = row_age;
                use_nxt     = di_r;
                use_mac_nxt = row_mac;
              end
            end
            ACT_LOOKUP: begin
              if (cmp.pa_eq) begin
                done        = 1'b1;
                res_st_nxt  = row_valid ? ST_HIT : ST_PENDING;
                res_mac_nxt = row_valid ? row_mac : '0;
                res_idx_nxt = di_r;
              end
            end
            ACT_ADD: begin
              if (!row_valid) begin
                wr_en       = 1'b1;
                wr_age      = op_age_r;
                done        = 1'b1;
                res_st_nxt  = ST_DONE;
                res_idx_nxt = di_r;
              end
            end
            ACT_REMOVE: begin
              if (cmp.pa_eq && cmp.mac_eq) begin
                clr_en      = 1'b1;
                done        = 1'b1;
                res_st_nxt  = ST_DONE;
                res_idx_nxt = di_r;
              end
            end
            default: begin
            end
          endcase
          if (done) begin
            dv_nxt    = 1'b0;
            state_nxt = S_EMIT;
          end else if (di_r == LAST_ROW) begin
            dv_nxt    = 1'b0;
            state_nxt = S_FIN;
          end
        end
      end

      S_FIN: begin
        state_nxt   = S_EMIT;
        res_st_nxt  = ST_DONE;
        res_idx_nxt = '0;
        unique case (op_act_r)
          ACT_REFRESH: begin
            wr_en = 1'b1;
            if (mac_fnd_r) begin
              wr_addr     = mac_row_r;
              res_idx_nxt = mac_row_r;
              clr_en      = pa_fnd_r;
              clr_addr    = pa_row_r;
            end else if (pa_fnd_r) begin
              wr_addr     = pa_row_r;
              res_idx_nxt = pa_row_r;
            end else begin
              wr_addr     = use_r;
              res_idx_nxt = use_r;
            end
          end
          ACT_RESERVE: begin
            // new pending row in the oldest slot, MAC kept
            wr_en       = 1'b1;
            wr_addr     = use_r;
            wr_mac      = use_mac_r;
            wr_age      = pend_age_r;
            wr_valid    = 1'b0;
            res_idx_nxt = use_r;
          end
          ACT_LOOKUP: begin
            res_st_nxt = ST_MISS;
          end
          default: begin
            res_st_nxt = ST_FAIL;
          end
        endcase
      end

      S_EMIT: begin
        if (emit_go) state_nxt = S_IDLE;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign idx_ext = {{IDX_OUT_W{1'b0}}, res_idx_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      dv_r        <= 1'b0;
      out_valid_r <= 1'b0;
      full_age_r  <= FULL_AGE_RST;
      pend_age_r  <= PENDING_AGE_RST;
    end else begin
      state_r <= state_nxt;
      dv_r    <= dv_nxt;
      if (emit_go) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_FULL_AGE:    full_age_r <= cfg_data;
          CFG_PENDING_AGE: pend_age_r <= cfg_data;
          default: begin
          end
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    cnt_r     <= cnt_nxt;
    di_r      <= di_nxt;
    pa_fnd_r  <= pa_fnd_nxt;
    pa_row_r  <= pa_row_nxt;
    mac_fnd_r <= mac_fnd_nxt;
    mac_row_r <= mac_row_nxt;
    min_r     <= min_nxt;
    use_r     <= use_nxt;
    use_mac_r <= use_mac_nxt;
    res_st_r  <= res_st_nxt;
    res_mac_r <= res_mac_nxt;
    res_idx_r <= res_idx_nxt;
    if (in_xfer) begin
      op_act_r <= in_ch.action;
      op_pa_r  <= in_ch.protocol_address[PAW-1:0];
      op_mac_r <= in_ch.hw_address;
      op_age_r <= in_ch.add_age;
    end
    if (emit_go) begin
      out_st_r  <= res_st_r;
      out_mac_r <= res_mac_r;
      out_idx_r <= idx_ext[IDX_OUT_W-1:0];
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.status      = out_st_r;
  assign out_ch.mac_out     = out_mac_r;
  assign out_ch.entry_index = out_idx_r;

`ifndef SYNTHESIS
  a_clear_short: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && (in_ch.action == ACT_CLEAR)) |=> (state_r == S_EMIT))
    else $error("clear action did not go straight to result");

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> (cnt_r <= N_C))
    else $error("scan counter past table depth");

  a_wr_phase: assert property (@(posedge clk) disable iff (!rst_n)
    (wr_en || clr_en) |-> ((state_r == S_SCAN) || (state_r == S_FIN)))
    else $error("row write outside scan or final step");

  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == S_EMIT))
    else $error("result valid without emit step");

  a_fail_idx: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_st_r == ST_FAIL)) |-> ((out_idx_r == '0) && (out_mac_r == '0)))
    else $error("failed action reports a row");
`endif

endmodule

@@ tb/testbench.sv @@
// Self-checking testbench for the ARP cache table core: directed and random requests.
`timescale 1ns / 1ps
module testbench;
  import arpc_pkg::*;

  localparam int ROWS            = DEF_CACHE_ENTRIES;
  localparam int ITEMS_PER_PHASE = 270;
  localparam int POOL            = 6;     // small address pools so rows collide often
  localparam int HOLD_CYCLES     = 500;   // long receiver hold-off
  localparam int STALL_LIMIT     = 6000;  // cycles with no transfer before giving up
  localparam int DRAIN_CYCLES    = 40;    // wait after the last phase for stray replies
  localparam int MAX_REPORTS     = 10;

  // the action field is 3 bits wide; these two codes are undefined
  localparam logic [ACT_W-1:0]   ACT_BAD_LO = 3'd6;
  localparam logic [ACT_W-1:0]   ACT_BAD_HI = 3'd7;
  localparam logic [PA_IN_W-1:0] PA_ONES    = '1;
  localparam logic [MAC_W-1:0]   MAC_ONES   = '1;

  typedef struct packed {
    logic [ACT_W-1:0]   action;
    logic [PA_IN_W-1:0] pa;
    logic [MAC_W-1:0]   mac;
    logic [AGE_W-1:0]   age;
  } arp_req_t;

  typedef struct packed {
    logic [ST_W-1:0]      status;
    logic [MAC_W-1:0]     mac;
    logic [IDX_OUT_W-1:0] row;
  } arp_reply_t;

  logic clk = 1'b0;
  logic rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;

  arpc_in_if  in_bus ();
  arpc_out_if out_bus ();

  arp_cache_table_core #(
    .CACHE_ENTRIES (ROWS),
    .PA_BITS       (DEF_PA_BITS)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_bus),
    .out_ch    (out_bus),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #2 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Cache shadow: our own copy of the row store and the two age registers.
  // Rows are matched without regard to the valid bit, as the block does.
  // ---------------------------------------------------------------------------
  logic [PA_IN_W-1:0] row_pa    [ROWS];
  logic [MAC_W-1:0]   row_mac   [ROWS];
  logic [AGE_W-1:0]   row_age   [ROWS];
  logic               row_valid [ROWS];
  logic [CFG_W-1:0]   cur_full_age = FULL_AGE_RST;
  logic [CFG_W-1:0]   cur_pending_age = PENDING_AGE_RST;

  function automatic void wipe_row(input int r);
    row_pa[r]    = '0;
    row_mac[r]   = '0;
    row_age[r]   = '0;
    row_valid[r] = 1'b0;
  endfunction

  // Learn an address (have_mac) or reserve it pending (!have_mac).
  // Returns the row written.
  function automatic int cache_learn(input logic [PA_IN_W-1:0] pa,
                                     input logic [MAC_W-1:0] mac, input bit have_mac);
    int pa_row, mac_row, victim;
    logic [AGE_W-1:0] min_age;
    bit mac_eq;
    pa_row  = -1;
    mac_row = -1;
    victim  = 0;
    min_age = AGE_MAX;
    for (int r = 0; r < ROWS; r++) begin
      mac_eq = have_mac && (row_mac[r] == mac);
      if (row_pa[r] == pa) begin
        if (!have_mac) begin
          pa_row = r;
          break;
        end
        if (mac_eq) begin
          // both addresses agree: just renew it
          row_age[r]   = cur_full_age;
          row_valid[r] = 1'b1;
          return r;
        end
        pa_row = r;
      end else if (mac_eq) begin
        mac_row = r;
      end else if (row_age[r] < min_age) begin
        // oldest candidate: first row of strictly lowest age below the max
        min_age = row_age[r];
        victim  = r;
      end
    end
    if (mac_row >= 0) begin
      victim = mac_row;
      if (pa_row >= 0) wipe_row(pa_row);  // stale row for this address goes away
    end else if (pa_row >= 0) begin
      victim = pa_row;
    end
    row_pa[victim] = pa;
    if (have_mac) begin
      row_mac[victim]   = mac;
      row_age[victim]   = cur_full_age;
      row_valid[victim] = 1'b1;
    end else if (pa_row < 0) begin
      row_age[victim]   = cur_pending_age;
      row_valid[victim] = 1'b0;
    end
    return victim;
  endfunction

  // Apply one request to the shadow and return the reply it must produce.
  function automatic arp_reply_t cache_apply(input logic [ACT_W-1:0] action,
                                             input logic [PA_IN_W-1:0] pa,
                                             input logic [MAC_W-1:0] mac,
                                             input logic [AGE_W-1:0] age);
    arp_reply_t rep;
    int r;
    rep = '0;
    rep.status = ST_FAIL;
    case (action)
      ACT_REFRESH: begin
        r = cache_learn(pa, mac, 1'b1);
        rep.status = ST_DONE;
        rep.row    = r[IDX_OUT_W-1:0];
      end
      ACT_RESERVE: begin
        r = cache_learn(pa, '0, 1'b0);
        rep.status = ST_DONE;
        rep.row    = r[IDX_OUT_W-1:0];
      end
      ACT_LOOKUP: begin
        rep.status = ST_MISS;
        for (r = 0; r < ROWS; r++) begin
          if (row_pa[r] == pa) begin
            rep.status = row_valid[r] ? ST_HIT : ST_PENDING;
            rep.mac    = row_valid[r] ? row_mac[r] : '0;
            rep.row    = r[IDX_OUT_W-1:0];
            break;
          end
        end
      end
      ACT_ADD: begin
        for (r = 0; r < ROWS; r++) begin
          if (!row_valid[r]) begin
            row_pa[r]    = pa;
            row_mac[r]   = mac;
            row_age[r]   = age;
            row_valid[r] = 1'b1;
            rep.status   = ST_DONE;
            rep.row      = r[IDX_OUT_W-1:0];
            break;
          end
        end
      end
      ACT_REMOVE: begin
        for (r = 0; r < ROWS; r++) begin
          if (row_mac[r] == mac && row_pa[r] == pa) begin
            wipe_row(r);
            rep.status = ST_DONE;
            rep.row    = r[IDX_OUT_W-1:0];
            break;
          end
        end
      end
      ACT_CLEAR: begin
        for (r = 0; r < ROWS; r++) wipe_row(r);
        rep.status = ST_DONE;
      end
      default: rep.status = ST_FAIL;
    endcase
    return rep;
  endfunction

  // ---------------------------------------------------------------------------
  // Shared bookkeeping
  // ---------------------------------------------------------------------------
  arp_req_t   pending_requests[$];   // filled by the stimulus, drained by the driver
  arp_reply_t expected_replies[$];   // one per accepted request, oldest first

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int hold_seq       = 0;   // bump to ask the receiver for a long hold-off
  int queued_items   = 0;   // requests with a defined action
  int errors         = 0;
  int replies_seen   = 0;
  int act_seen [8];
  int lookup_status [8];
  int add_full       = 0;
  int remove_miss    = 0;

  logic [PA_IN_W-1:0] pa_pool  [POOL];
  logic [MAC_W-1:0]   mac_pool [POOL];

  // ---------------------------------------------------------------------------
  // Request driver: offers the next pending request, idling at random.
  // Valid is assigned once per edge, so back-to-back transfers keep it high.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : request_driver
    arp_req_t   nxt;
    arp_reply_t rep;
    if (!rst_n) begin
      in_bus.valid <= 1'b0;
    end else begin
      if (in_bus.valid && in_bus.ready) begin
        rep = cache_apply(in_bus.action, in_bus.protocol_address,
                          in_bus.hw_address, in_bus.add_age);
        expected_replies.push_back(rep);
        act_seen[in_bus.action]++;
        if (in_bus.action == ACT_LOOKUP) lookup_status[rep.status]++;
        if (in_bus.action == ACT_ADD && rep.status == ST_FAIL) add_full++;
        if (in_bus.action == ACT_REMOVE && rep.status == ST_FAIL) remove_miss++;
      end
      if (!in_bus.valid || in_bus.ready) begin
        if (pending_requests.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          nxt = pending_requests.pop_front();
          in_bus.valid            <= 1'b1;
          in_bus.action           <= nxt.action;
          in_bus.protocol_address <= nxt.pa;
          in_bus.hw_address       <= nxt.mac;
          in_bus.add_age          <= nxt.age;
        end else begin
          in_bus.valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Reply monitor: checks each transfer against the oldest expectation and
  // drives ready, including the long hold-off counted here.
  // ---------------------------------------------------------------------------
  task automatic flag_reply(input string why, input arp_reply_t want, input arp_reply_t got);
    errors++;
    if (errors <= MAX_REPORTS)
      $display("mismatch (%s): want st %0d mac %h row %0d, got st %0d mac %h row %0d",
               why, want.status, want.mac, want.row, got.status, got.mac, got.row);
  endtask

  always @(posedge clk) begin : reply_monitor
    arp_reply_t want, got;
    int hold_seen;
    int hold_left;
    if (!rst_n) begin
      out_bus.ready <= 1'b0;
      hold_seen = hold_seq;
      hold_left = 0;
    end else begin
      if (out_bus.valid && out_bus.ready) begin
        replies_seen++;
        got = {out_bus.status, out_bus.mac_out, out_bus.entry_index};
        if (expected_replies.size() == 0) begin
          flag_reply("reply with nothing outstanding", '0, got);
        end else begin
          want = expected_replies.pop_front();
          if (got !== want) flag_reply("reply fields", want, got);
        end
      end
      if (hold_seq != hold_seen) begin
        hold_seen = hold_seq;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_bus.ready <= 1'b0;
      end else begin
        out_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Watchdog: too long without a transfer on either channel means a hang.
  int quiet_cycles;
  always @(posedge clk) begin : watchdog
    if (!rst_n) begin
      quiet_cycles <= 0;
    end else if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("timeout: no transfer for %0d cycles", STALL_LIMIT);
      $display("[arp_cache_table_core] ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic logic [MAC_W-1:0] fresh_mac();
    logic [63:0] w;
    w = {$urandom(), $urandom()};
    return w[MAC_W-1:0];
  endfunction

  function automatic logic [PA_IN_W-1:0] pick_pa();
    int r;
    r = $urandom_range(99);
    if (r < 65) return pa_pool[$urandom_range(POOL-1)];
    if (r < 75) return '0;
    if (r < 80) return PA_ONES;
    return $urandom();
  endfunction

  function automatic logic [MAC_W-1:0] pick_mac();
    int r;
    r = $urandom_range(99);
    if (r < 65) return mac_pool[$urandom_range(POOL-1)];
    if (r < 75) return '0;
    if (r < 80) return MAC_ONES;
    return fresh_mac();
  endfunction

  function automatic logic [AGE_W-1:0] pick_age();
    int r;
    r = $urandom_range(99);
    if (r < 25) return '0;
    if (r < 50) return AGE_MAX;
    return AGE_W'($urandom_range(255));
  endfunction

  task automatic queue_req(input logic [ACT_W-1:0] action, input logic [PA_IN_W-1:0] pa,
                           input logic [MAC_W-1:0] mac, input logic [AGE_W-1:0] age);
    arp_req_t q;
    q.action = action;
    q.pa     = pa;
    q.mac    = mac;
    q.age    = age;
    pending_requests.push_back(q);
    if (action <= ACT_CLEAR) queued_items++;
  endtask

  // Empty the table, fill every row, overflow it, then learn a new address and look one up.
  // With every age at the max the new address lands in row 0.
  task automatic fill_sequence(input bit all_max);
    queue_req(ACT_CLEAR, pick_pa(), pick_mac(), pick_age());
    for (int i = 0; i < ROWS; i++)
      queue_req(ACT_ADD, pick_pa(), pick_mac(), all_max ? AGE_MAX : pick_age());
    queue_req(ACT_ADD, pick_pa(), pick_mac(), pick_age());
    queue_req(ACT_REFRESH, $urandom(), fresh_mac(), pick_age());
    queue_req(ACT_LOOKUP, pick_pa(), pick_mac(), pick_age());
  endtask

  // Typical resolution: reserve, query, reply arrives, query, maybe remove and query again.
  task automatic resolve_sequence();
    logic [PA_IN_W-1:0] pa;
    logic [MAC_W-1:0]   mac;
    pa  = pick_pa();
    mac = pick_mac();
    queue_req(ACT_RESERVE, pa, pick_mac(), pick_age());
    queue_req(ACT_LOOKUP, pa, pick_mac(), pick_age());
    queue_req(ACT_REFRESH, pa, mac, pick_age());
    queue_req(ACT_LOOKUP, pa, pick_mac(), pick_age());
    if ($urandom_range(1)) begin
      queue_req(ACT_REMOVE, pa, mac, pick_age());
      queue_req(ACT_LOOKUP, pa, pick_mac(), pick_age());
    end
  endtask

  task automatic random_step();
    int r;
    logic [ACT_W-1:0] a;
    r = $urandom_range(99);
    if (r < 20) begin
      resolve_sequence();
    end else if (r < 23) begin
      fill_sequence(1'($urandom_range(1)));
    end else begin
      r = $urandom_range(99);
      if (r < 22)      a = ACT_REFRESH;
      else if (r < 34) a = ACT_RESERVE;
      else if (r < 58) a = ACT_LOOKUP;
      else if (r < 72) a = ACT_ADD;
      else if (r < 86) a = ACT_REMOVE;
      else if (r < 90) a = ACT_CLEAR;
      else if (r < 95) a = ACT_BAD_LO;
      else             a = ACT_BAD_HI;
      queue_req(a, pick_pa(), pick_mac(), pick_age());
    end
  endtask

  // Idle point: nothing queued, nothing offered, every reply back.
  task automatic wait_idle();
    do @(negedge clk);
    while (pending_requests.size() != 0 || in_bus.valid || expected_replies.size() != 0);
  endtask

  // Registers change only at an idle point; the shadow follows immediately.
  task automatic program_ages(input logic [CFG_W-1:0] full, input logic [CFG_W-1:0] pend);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_FULL_AGE;
    cfg_data  <= full;
    @(posedge clk);
    cfg_index <= CFG_PENDING_AGE;
    cfg_data  <= pend;
    @(posedge clk);
    cfg_we <= 1'b0;
    cur_full_age    = full;
    cur_pending_age = pend;
  endtask

  // One traffic phase. hold_out asks for a long receiver hold-off while the
  // sender keeps offering; pause_in lets the sender drain halfway through.
  task automatic run_phase(input int n, input int snd_pct, input int rcv_pct,
                           input bit hold_out, input bit pause_in);
    int goal, half;
    send_idle_pct  = snd_pct;
    recv_stall_pct = rcv_pct;
    goal = queued_items + n;
    half = queued_items + n / 2;
    if (hold_out) hold_seq++;
    while (queued_items < goal) begin
      random_step();
      if (pause_in && queued_items >= half) begin
        pause_in = 1'b0;
        wait_idle();
      end
    end
    wait_idle();
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin : main
    logic [PA_IN_W-1:0] pa_a, pa_b;
    logic [MAC_W-1:0]   mac_a;

    rst_n     = 1'b0;
    cfg_we    = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    in_bus.valid            = 1'b0;
    in_bus.action           = '0;
    in_bus.protocol_address = '0;
    in_bus.hw_address       = '0;
    in_bus.add_age          = '0;
    out_bus.ready           = 1'b0;
    for (int r = 0; r < ROWS; r++) wipe_row(r);
    for (int i = 0; i < POOL; i++) begin
      pa_pool[i]  = $urandom();
      mac_pool[i] = fresh_mac();
    end
    pa_a  = $urandom() | 32'h100;
    pa_b  = pa_a ^ 32'h8000_0001;
    mac_a = fresh_mac() | 48'h1;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // directed part, reset register values
    queue_req(ACT_LOOKUP, '0, '0, '0);               // cleared rows answer pending
    queue_req(ACT_LOOKUP, PA_ONES, MAC_ONES, AGE_MAX); // miss
    queue_req(ACT_RESERVE, pa_a, '0, '0);
    queue_req(ACT_LOOKUP, pa_a, '0, '0);
    queue_req(ACT_RESERVE, pa_a, '0, '0);            // known address: age/valid kept
    queue_req(ACT_REFRESH, pa_a, mac_a, '0);         // reply for the pending row
    queue_req(ACT_REFRESH, pa_a, mac_a, '0);         // exact match renews
    queue_req(ACT_LOOKUP, pa_a, '0, '0);             // hit returns the MAC
    queue_req(ACT_REFRESH, pa_b, mac_a, '0);         // MAC moves to a new address
    queue_req(ACT_RESERVE, pa_a, '0, '0);
    queue_req(ACT_REFRESH, pa_a, mac_a, '0);         // MAC row reused, address row cleared
    queue_req(ACT_REFRESH, PA_ONES, MAC_ONES, AGE_MAX);
    queue_req(ACT_LOOKUP, PA_ONES, '0, '0);
    queue_req(ACT_REMOVE, PA_ONES, MAC_ONES, '0);
    queue_req(ACT_REMOVE, PA_ONES, MAC_ONES, '0);    // nothing left to remove
    queue_req(ACT_ADD, PA_ONES, MAC_ONES, AGE_MAX);
    queue_req(ACT_ADD, '0, '0, '0);
    queue_req(ACT_BAD_LO, PA_ONES, MAC_ONES, AGE_MAX);
    queue_req(ACT_BAD_HI, '0, '0, '0);
    queue_req(ACT_CLEAR, PA_ONES, MAC_ONES, AGE_MAX);
    queue_req(ACT_LOOKUP, pa_a, '0, '0);
    fill_sequence(1'b1);                             // full table, oldest-row fallback
    wait_idle();

    // random phases, each at its own register setting, with varied idling
    run_phase(ITEMS_PER_PHASE, 0, 0, 1'b1, 1'b0);
    program_ages('0, '0);
    run_phase(ITEMS_PER_PHASE, 76, 0, 1'b0, 1'b1);
    program_ages(AGE_MAX, AGE_MAX);
    run_phase(ITEMS_PER_PHASE, 0, 76, 1'b0, 1'b0);
    program_ages(CFG_W'($urandom_range(1, 254)), CFG_W'($urandom_range(1, 254)));
    run_phase(ITEMS_PER_PHASE, 7, 7, 1'b0, 1'b0);
    program_ages(AGE_MAX, '0);
    run_phase(ITEMS_PER_PHASE, 0, 0, 1'b1, 1'b1);

    // let any stray reply show up before judging
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d replies: refresh %0d, reserve %0d, lookup %0d, add %0d,",
             replies_seen, act_seen[ACT_REFRESH], act_seen[ACT_RESERVE],
             act_seen[ACT_LOOKUP], act_seen[ACT_ADD]);
    $display("  remove %0d, clear %0d, undef %0d; hit/pend/miss %0d/%0d/%0d; full %0d, no-rm %0d",
             act_seen[ACT_REMOVE], act_seen[ACT_CLEAR],
             act_seen[ACT_BAD_LO] + act_seen[ACT_BAD_HI],
             lookup_status[ST_HIT], lookup_status[ST_PENDING], lookup_status[ST_MISS],
             add_full, remove_miss);
    if (errors == 0) begin
      $display("[arp_cache_table_core] OK");
    end else begin
      $display("%0d mismatches", errors);
      $display("[arp_cache_table_core] ERROR");
    end
    $finish;
  end

endmodule
